@@ src/sdh_pkg.sv @@
// ----------------------------------------------------------------------------
// sdh_pkg
// Shared types, codes and sizes of the SD card SPI-mode host sequencer.
// ----------------------------------------------------------------------------
package sdh_pkg;

  // Host block size and counter widths
  localparam int BLOCK_BYTES = 512;
  localparam int CARD_BLOCK  = 512;
  localparam int BC_MAX      = (BLOCK_BYTES > CARD_BLOCK) ? BLOCK_BYTES : CARD_BLOCK;
  localparam int BC_W        = $clog2(BC_MAX + 1);

  // Result queue
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READY_WAIT = 2'd0,
    CFG_TOKEN_WAIT = 2'd1,
    CFG_INIT_RETRY = 2'd2,
    CFG_RESP_POLL  = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] READY_WAIT_RST = 16'd10000;
  localparam logic [15:0] TOKEN_WAIT_RST = 16'd1000;
  localparam logic [15:0] INIT_RETRY_RST = 16'd1000;
  localparam logic [7:0]  RESP_POLL_RST  = 8'd10;

  // Input item codes
  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_CARD  = 3'd3;
  localparam logic [2:0] CMD_WDATA = 3'd4;

  // Result kinds
  localparam logic [1:0] K_BUS  = 2'd0;
  localparam logic [1:0] K_DATA = 2'd1;
  localparam logic [1:0] K_WANT = 2'd2;
  localparam logic [1:0] K_DONE = 2'd3;

  // Done status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_READY_TO  = 3'd1;
  localparam logic [2:0] ST_CMD_REJ   = 3'd2;
  localparam logic [2:0] ST_BAD_TOKEN = 3'd3;
  localparam logic [2:0] ST_WR_REJ    = 3'd4;
  localparam logic [2:0] ST_INIT_FAIL = 3'd5;
  localparam logic [2:0] ST_BAD_LEN   = 3'd6;

  // Card types
  localparam logic [1:0] CT_UNKNOWN = 2'd0;
  localparam logic [1:0] CT_MMC     = 2'd1;
  localparam logic [1:0] CT_SD1     = 2'd2;
  localparam logic [1:0] CT_SD2     = 2'd3;

  // SPI bytes and command indexes
  localparam logic [7:0] B_IDLE    = 8'hFF;
  localparam logic [7:0] B_TOKEN   = 8'hFE;
  localparam logic [7:0] APP_FLAG  = 8'h80;
  localparam logic [7:0] C_CMD0    = 8'd0;
  localparam logic [7:0] C_CMD1    = 8'd1;
  localparam logic [7:0] C_CMD8    = 8'd8;
  localparam logic [7:0] C_CMD16   = 8'd16;
  localparam logic [7:0] C_CMD17   = 8'd17;
  localparam logic [7:0] C_CMD24   = 8'd24;
  localparam logic [7:0] C_CMD58   = 8'd58;
  localparam logic [7:0] C_ACMD41  = 8'h80 | 8'd41;

  // Configuration values handed to the core
  typedef struct packed {
    logic [15:0] ready_wait;
    logic [15:0] token_wait;
    logic [15:0] init_retry;
    logic [7:0]  resp_poll;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] bus_byte;
    logic       chip_select;
    logic [2:0] status;
    logic [1:0] card_kind;
    logic       block_addressing;
    logic       last;
  } res_t;

  // Push request from the core to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Command frame byte: index, argument MSB first, CRC
  function automatic logic [7:0] frame_byte(input logic [2:0] i, input logic app,
                                            input logic [7:0] cc, input logic [31:0] ca);
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [7:0]  b;
    idx = app ? 6'd55 : cc[5:0];
    arg = app ? 32'd0 : ca;
    case (i)
      3'd0:    b = {2'b01, idx};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = (idx == 6'd0) ? 8'h95 : ((idx == 6'd8) ? 8'h87 : 8'h01);
    endcase
    return b;
  endfunction

endpackage

@@ src/sdh_if.sv @@
// ----------------------------------------------------------------------------
// sdh_in_if / sdh_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface sdh_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] sector;
  logic [7:0]  byte_in;

  modport source (output valid, cmd, sector, byte_in, input ready);
  modport sink   (input valid, cmd, sector, byte_in, output ready);
endinterface

interface sdh_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] bus_byte;
  logic       chip_select;
  logic [2:0] status;
  logic [1:0] card_kind;
  logic       block_addressing;
  logic       last;

  modport source (output valid, kind, bus_byte, chip_select, status, card_kind,
                  block_addressing, last, input ready);
  modport sink   (input valid, kind, bus_byte, chip_select, status, card_kind,
                  block_addressing, last, output ready);
endinterface

@@ src/sdh_cfg.sv @@
// ----------------------------------------------------------------------------
// sdh_cfg
// Configuration register file: poll and retry limits.
// ----------------------------------------------------------------------------
module sdh_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          we,
  input  logic [sdh_pkg::CFG_IDX_W-1:0] idx,
  input  logic [15:0]                   data,
  output sdh_pkg::cfg_t                 cfg
);
  import sdh_pkg::*;

  cfg_t cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready_wait <= READY_WAIT_RST;
      cfg_r.token_wait <= TOKEN_WAIT_RST;
      cfg_r.init_retry <= INIT_RETRY_RST;
      cfg_r.resp_poll  <= RESP_POLL_RST;
    end else if (we) begin
      case (cfg_idx_e'(idx))
        CFG_READY_WAIT: cfg_r.ready_wait <= data;
        CFG_TOKEN_WAIT: cfg_r.token_wait <= data;
        CFG_INIT_RETRY: cfg_r.init_retry <= data;
        CFG_RESP_POLL:  cfg_r.resp_poll  <= data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

@@ src/sdh_core.sv @@
// ----------------------------------------------------------------------------
// sdh_core
// Input register and one-pass protocol step: decides the next bus byte.
// ----------------------------------------------------------------------------
module sdh_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_take,
  input  logic [2:0]     in_cmd,
  input  logic [31:0]    in_sector,
  input  logic [7:0]     in_byte,
  input  sdh_pkg::cfg_t  cfg,
  output sdh_pkg::push_t push
);
  import sdh_pkg::*;

  typedef enum logic [4:0] {
    P_IDLE, P_I_CLK, P_I_CMD0, P_I_CMD8, P_I_R7, P_I_V2, P_I_CMD58, P_I_OCR,
    P_I_PROBE, P_I_V1, P_I_CMD16, P_RD_CMD, P_RD_TOKEN, P_RD_DATA, P_RD_CRC,
    P_WR_CMD, P_WR_READY, P_WR_TOKEN, P_WR_WANT, P_WR_DATA, P_WR_CRC, P_WR_RESP,
    P_WR_BUSY, P_WR_DUMMY, P_FINAL
  } phase_t;

  typedef enum logic [2:0] {
    CE_NONE, CE_DESEL, CE_SEL, CE_READY, CE_FRAME, CE_R1, CE_FAIL
  } stage_t;

  // Input register
  logic        iv_r;
  logic [2:0]  icmd_r;
  logic [31:0] isec_r;
  logic [7:0]  ibyte_r;

  // Sequencer state
  phase_t      ph_r, ph_nxt;
  stage_t      st_r, st_nxt;
  logic [1:0]  ct_r, ct_nxt;
  logic        ba_r, ba_nxt;
  logic [15:0] rc_r, rc_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [BC_W-1:0] bc_r, bc_nxt;
  logic [2:0]  fi_r, fi_nxt;
  logic [7:0]  cc_r, cc_nxt;
  logic [31:0] ca_r, ca_nxt;
  logic [7:0]  lr_r, lr_nxt;
  logic [15:0] rxw_r, rxw_nxt;
  logic        ocr_r, ocr_nxt;
  logic [2:0]  fs_r, fs_nxt;
  logic        cs_r, cs_nxt;
  logic        app_r, app_nxt;
  logic        to_r, to_nxt;

  push_t       push_nxt;

  always_comb begin
    logic        e_en;
    logic [1:0]  e_kind;
    logic [7:0]  e_byte;
    logic [2:0]  e_st;
    logic        rd;
    logic        sc;
    logic [7:0]  scc;
    logic [31:0] sca;
    logic        eg;
    logic        fc;
    logic [7:0]  fr;
    logic        fto;
    logic        fo;
    logic [2:0]  fst;
    logic        fin;
    logic [31:0] arg;
    res_t        rb;
    res_t        rdat;

    ph_nxt = ph_r;   st_nxt = st_r;   ct_nxt = ct_r;   ba_nxt = ba_r;
    rc_nxt = rc_r;   pc_nxt = pc_r;   bc_nxt = bc_r;   fi_nxt = fi_r;
    cc_nxt = cc_r;   ca_nxt = ca_r;   lr_nxt = lr_r;   rxw_nxt = rxw_r;
    ocr_nxt = ocr_r; fs_nxt = fs_r;   cs_nxt = cs_r;   app_nxt = app_r;
    to_nxt = to_r;
    e_en = 1'b0; e_kind = K_BUS; e_byte = 8'h00; e_st = ST_OK;
    rd = 1'b0; sc = 1'b0; scc = 8'h00; sca = 32'd0; eg = 1'b0;
    fc = 1'b0; fr = 8'h00; fto = 1'b0; fo = 1'b0; fst = ST_OK; fin = 1'b0;
    arg = ba_r ? isec_r : {isec_r[22:0], 9'd0};

    if (iv_r) begin
      case (icmd_r)
        CMD_INIT, CMD_READ, CMD_WRITE: begin
          if (ph_r == P_IDLE) begin
            if (icmd_r == CMD_INIT) begin
              ct_nxt = CT_UNKNOWN; ba_nxt = 1'b0; bc_nxt = '0; ph_nxt = P_I_CLK;
              e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b0;
            end else if (icmd_r == CMD_READ) begin
              ph_nxt = P_RD_CMD; sc = 1'b1; scc = C_CMD17; sca = arg;
            end else begin
              ph_nxt = P_WR_CMD; sc = 1'b1; scc = C_CMD24; sca = arg;
            end
          end
        end
        CMD_WDATA: begin
          if (ph_r == P_WR_WANT) begin
            ph_nxt = P_WR_DATA; e_en = 1'b1; e_byte = ibyte_r; cs_nxt = 1'b1;
          end
        end
        CMD_CARD: begin
          if (ph_r != P_IDLE && ph_r != P_WR_WANT) begin
            if (st_r != CE_NONE) begin
              // Command engine: select, ready poll, frame, R1 poll
              case (st_r)
                CE_DESEL: begin
                  st_nxt = CE_SEL; e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                end
                CE_SEL: begin
                  pc_nxt = '0; st_nxt = CE_READY;
                  e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                end
                CE_READY: begin
                  if (ibyte_r == B_IDLE) begin
                    fi_nxt = '0; st_nxt = CE_FRAME; e_en = 1'b1; cs_nxt = 1'b1;
                    e_byte = frame_byte(3'd0, app_r, cc_r, ca_r);
                  end else begin
                    pc_nxt = pc_r + 16'd1;
                    e_en = 1'b1; e_byte = B_IDLE;
                    if (pc_nxt >= cfg.ready_wait) begin
                      st_nxt = CE_FAIL; cs_nxt = 1'b0;
                    end else begin
                      cs_nxt = 1'b1;
                    end
                  end
                end
                CE_FRAME: begin
                  fi_nxt = fi_r + 3'd1;
                  e_en = 1'b1; cs_nxt = 1'b1;
                  if (fi_nxt < 3'd6) begin
                    e_byte = frame_byte(fi_nxt, app_r, cc_r, ca_r);
                  end else begin
                    pc_nxt = '0; st_nxt = CE_R1; e_byte = B_IDLE;
                  end
                end
                CE_R1: begin
                  pc_nxt = pc_r + 16'd1;
                  if (!ibyte_r[7] || pc_nxt >= {8'd0, cfg.resp_poll}) begin
                    fc = 1'b1; fr = ibyte_r; fto = 1'b0;
                  end else begin
                    e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                  end
                end
                CE_FAIL: begin
                  fc = 1'b1; fr = B_IDLE; fto = 1'b1;
                end
                default: st_nxt = CE_NONE;
              endcase
            end else begin
              // Operation phases between commands
              case (ph_r)
                P_I_CLK: begin
                  bc_nxt = bc_r + 1'b1;
                  if (bc_nxt < BC_W'(10)) begin
                    e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b0;
                  end else begin
                    ph_nxt = P_I_CMD0; sc = 1'b1; scc = C_CMD0; sca = 32'd0;
                  end
                end
                P_I_R7: begin
                  rxw_nxt = {rxw_r[7:0], ibyte_r}; bc_nxt = bc_r + 1'b1;
                  if (bc_nxt < BC_W'(4)) begin
                    e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                  end else if (rxw_nxt == 16'h01AA) begin
                    rc_nxt = '0; ph_nxt = P_I_V2;
                    sc = 1'b1; scc = C_ACMD41; sca = 32'h4000_0000;
                  end else begin
                    fin = 1'b1;
                  end
                end
                P_I_OCR: begin
                  if (bc_r == '0) ocr_nxt = ibyte_r[6];
                  bc_nxt = bc_r + 1'b1;
                  if (bc_nxt < BC_W'(4)) begin
                    e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                  end else begin
                    ct_nxt = CT_SD2; ba_nxt = ocr_nxt; fin = 1'b1;
                  end
                end
                P_RD_TOKEN: begin
                  if (ibyte_r != B_IDLE) begin
                    if (ibyte_r == B_TOKEN) begin
                      bc_nxt = '0; ph_nxt = P_RD_DATA;
                      e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                    end else begin
                      fo = 1'b1; fst = ST_BAD_TOKEN;
                    end
                  end else begin
                    pc_nxt = pc_r + 16'd1;
                    if (pc_nxt >= cfg.token_wait) begin
                      fo = 1'b1; fst = ST_BAD_TOKEN;
                    end else begin
                      e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                    end
                  end
                end
                P_RD_DATA: begin
                  rd = 1'b1; bc_nxt = bc_r + 1'b1;
                  if (bc_nxt >= BC_W'(CARD_BLOCK)) begin
                    bc_nxt = '0; ph_nxt = P_RD_CRC;
                  end
                  e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                end
                P_RD_CRC: begin
                  bc_nxt = bc_r + 1'b1;
                  if (bc_nxt < BC_W'(2)) begin
                    e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                  end else begin
                    fo = 1'b1; fst = ST_OK;
                  end
                end
                P_WR_READY: begin
                  if (ibyte_r == B_IDLE) begin
                    ph_nxt = P_WR_TOKEN; e_en = 1'b1; e_byte = B_TOKEN; cs_nxt = 1'b1;
                  end else begin
                    pc_nxt = pc_r + 16'd1;
                    if (pc_nxt >= cfg.ready_wait) begin
                      fo = 1'b1; fst = ST_READY_TO;
                    end else begin
                      e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                    end
                  end
                end
                P_WR_TOKEN: begin
                  bc_nxt = '0; ph_nxt = P_WR_WANT; e_en = 1'b1; e_kind = K_WANT;
                end
                P_WR_DATA: begin
                  bc_nxt = bc_r + 1'b1;
                  if (bc_nxt < BC_W'(BLOCK_BYTES)) begin
                    ph_nxt = P_WR_WANT; e_en = 1'b1; e_kind = K_WANT;
                  end else begin
                    bc_nxt = '0; ph_nxt = P_WR_CRC;
                    e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                  end
                end
                P_WR_CRC: begin
                  bc_nxt = bc_r + 1'b1;
                  if (bc_nxt >= BC_W'(2)) ph_nxt = P_WR_RESP;
                  e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                end
                P_WR_RESP: begin
                  if (ibyte_r[4:0] != 5'h05) begin
                    fo = 1'b1; fst = ST_WR_REJ;
                  end else begin
                    ph_nxt = P_WR_BUSY; e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                  end
                end
                P_WR_BUSY: begin
                  if (ibyte_r != 8'h00) begin
                    bc_nxt = '0; ph_nxt = P_WR_DUMMY;
                  end
                  e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                end
                P_WR_DUMMY: begin
                  bc_nxt = bc_r + 1'b1;
                  if (bc_nxt < BC_W'(6)) begin
                    e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
                  end else begin
                    fo = 1'b1; fst = ST_OK;
                  end
                end
                P_FINAL: begin
                  ph_nxt = P_IDLE; cs_nxt = 1'b0;
                  e_en = 1'b1; e_kind = K_DONE; e_st = fs_r;
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    // Command finished: APP prefix step, then per-phase response handling
    if (fc) begin
      st_nxt = CE_NONE;
      if (app_r && fr <= 8'd1) begin
        app_nxt = 1'b0; to_nxt = 1'b0; eg = 1'b1;
      end else begin
        app_nxt = 1'b0; lr_nxt = fr; to_nxt = fto;
        case (ph_r)
          P_I_CMD0: begin
            if (fr != 8'd1) fin = 1'b1;
            else begin
              ph_nxt = P_I_CMD8; sc = 1'b1; scc = C_CMD8; sca = 32'h0000_01AA;
            end
          end
          P_I_CMD8: begin
            if (fr == 8'd1) begin
              bc_nxt = '0; rxw_nxt = '0; ph_nxt = P_I_R7;
              e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
            end else begin
              ph_nxt = P_I_PROBE; sc = 1'b1; scc = C_ACMD41; sca = 32'd0;
            end
          end
          P_I_V2: begin
            if (fr == 8'd0) begin
              ph_nxt = P_I_CMD58; sc = 1'b1; scc = C_CMD58; sca = 32'd0;
            end else begin
              rc_nxt = rc_r + 16'd1;
              if (rc_nxt >= cfg.init_retry) fin = 1'b1;
              else begin
                sc = 1'b1; scc = cc_r; sca = ca_r;
              end
            end
          end
          P_I_CMD58: begin
            if (fr == 8'd0) begin
              bc_nxt = '0; rxw_nxt = '0; ph_nxt = P_I_OCR;
              e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
          P_I_PROBE: begin
            sc = 1'b1; sca = 32'd0; rc_nxt = '0; ph_nxt = P_I_V1;
            if (fr <= 8'd1) begin
              ct_nxt = CT_SD1; scc = C_ACMD41;
            end else begin
              ct_nxt = CT_MMC; scc = C_CMD1;
            end
          end
          P_I_V1: begin
            if (fr == 8'd0) begin
              ph_nxt = P_I_CMD16; sc = 1'b1; scc = C_CMD16; sca = 32'(CARD_BLOCK);
            end else begin
              rc_nxt = rc_r + 16'd1;
              if (rc_nxt >= cfg.init_retry) begin
                ct_nxt = CT_UNKNOWN; fin = 1'b1;
              end else begin
                sc = 1'b1; scc = cc_r; sca = ca_r;
              end
            end
          end
          P_I_CMD16: begin
            if (fr != 8'd0) ct_nxt = CT_UNKNOWN;
            fin = 1'b1;
          end
          P_RD_CMD, P_WR_CMD: begin
            if (fto) begin
              fo = 1'b1; fst = ST_READY_TO;
            end else if (fr != 8'd0) begin
              fo = 1'b1; fst = ST_CMD_REJ;
            end else if (ph_r == P_WR_CMD && BLOCK_BYTES != CARD_BLOCK) begin
              fo = 1'b1; fst = ST_BAD_LEN;
            end else begin
              pc_nxt = '0; ph_nxt = (ph_r == P_RD_CMD) ? P_RD_TOKEN : P_WR_READY;
              e_en = 1'b1; e_byte = B_IDLE; cs_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    // Command start and operation end, both emit a deselect byte
    if (sc) begin
      cc_nxt = scc; ca_nxt = sca; app_nxt = scc[7]; to_nxt = 1'b0; eg = 1'b1;
    end
    if (eg) begin
      st_nxt = CE_DESEL; e_en = 1'b1; e_kind = K_BUS; e_byte = B_IDLE; cs_nxt = 1'b0;
    end
    if (fo || fin) begin
      fs_nxt = fin ? ((ct_nxt == CT_UNKNOWN) ? ST_INIT_FAIL : ST_OK) : fst;
      ph_nxt = P_FINAL; e_en = 1'b1; e_kind = K_BUS; e_byte = B_IDLE; e_st = ST_OK;
      cs_nxt = 1'b0;
    end

    // Result beats
    rb.kind = e_kind;           rb.bus_byte = e_byte;
    rb.chip_select = cs_nxt;    rb.status = e_st;
    rb.card_kind = ct_nxt;      rb.block_addressing = ba_nxt;
    rb.last = 1'b1;
    rdat.kind = K_DATA;         rdat.bus_byte = ibyte_r;
    rdat.chip_select = cs_r;    rdat.status = ST_OK;
    rdat.card_kind = ct_nxt;    rdat.block_addressing = ba_nxt;
    rdat.last = 1'b0;
    push_nxt.cnt = {1'b0, e_en} + {1'b0, rd};
    push_nxt.r0  = rd ? rdat : rb;
    push_nxt.r1  = rb;
  end

  // State and input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ph_r <= P_IDLE;  st_r <= CE_NONE; ct_r <= CT_UNKNOWN; ba_r <= 1'b0;
      rc_r <= '0;      pc_r <= '0;      bc_r <= '0;         fi_r <= '0;
      cc_r <= '0;      ca_r <= '0;      lr_r <= '0;         rxw_r <= '0;
      ocr_r <= 1'b0;   fs_r <= ST_OK;   cs_r <= 1'b0;       app_r <= 1'b0;
      to_r <= 1'b0;
    end else begin
      iv_r <= in_take;
      ph_r <= ph_nxt;  st_r <= st_nxt;  ct_r <= ct_nxt;     ba_r <= ba_nxt;
      rc_r <= rc_nxt;  pc_r <= pc_nxt;  bc_r <= bc_nxt;     fi_r <= fi_nxt;
      cc_r <= cc_nxt;  ca_r <= ca_nxt;  lr_r <= lr_nxt;     rxw_r <= rxw_nxt;
      ocr_r <= ocr_nxt; fs_r <= fs_nxt; cs_r <= cs_nxt;     app_r <= app_nxt;
      to_r <= to_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      icmd_r  <= in_cmd;
      isec_r  <= in_sector;
      ibyte_r <= in_byte;
    end
  end

  assign push = push_nxt;
endmodule

@@ src/sdh_rq.sv @@
// ----------------------------------------------------------------------------
// sdh_rq
// Result queue: takes up to two result beats a cycle, hands out one.
// ----------------------------------------------------------------------------
module sdh_rq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sdh_pkg::push_t           push,
  input  logic                     pop,
  output logic                     valid,
  output sdh_pkg::res_t            head,
  output logic [sdh_pkg::RQ_AW:0]  count
);
  import sdh_pkg::*;

  res_t              q_r [RQ_DEPTH];
  logic [RQ_AW-1:0]  wp_r, rp_r;
  logic [RQ_AW:0]    cnt_r, cnt_nxt;

  assign cnt_nxt = cnt_r + (RQ_AW+1)'(push.cnt) - (RQ_AW+1)'(pop);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + RQ_AW'(push.cnt);
      rp_r  <= rp_r + RQ_AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wp_r] <= push.r0;
    if (push.cnt == 2'd2) q_r[wp_r + RQ_AW'(1)] <= push.r1;
  end

  assign valid = (cnt_r != '0);
  assign head  = q_r[rp_r];
  assign count = cnt_r;
endmodule

@@ src/sd_card_spi_host_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer_top
// SD card SPI-mode host sequencer: init, block read and block write.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake          | Payload
// in_bus   | in  | valid/ready        | cmd, sector, byte_in
// out_bus  | out | valid/ready        | kind, bus_byte, chip_select, status,
//          |     |                    | card_kind, block_addressing, last
// cfg_*    | in  | cfg_we, no wait    | cfg_index, cfg_data
//
// One request beat per cycle while in_bus.ready is high; its results pass
// through the input register, then the result queue; up to two result beats per input.
// in_bus.ready drops while the 8-entry result queue holds more than four
// beats, so an output stall backs up the input after a few beats.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module sd_card_spi_host_sequencer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  sdh_in_if.sink                        in_bus,
  sdh_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [sdh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import sdh_pkg::*;

  cfg_t           cfg;
  push_t          push;
  res_t           head;
  logic [RQ_AW:0] rq_count;
  logic           in_take;

  // Room for the register in flight and the new beat
  assign in_bus.ready = (rq_count <= (RQ_AW+1)'(RQ_DEPTH - 4));
  assign in_take      = in_bus.valid & in_bus.ready;

  sdh_cfg u_cfg (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (cfg_we),
    .idx  (cfg_index),
    .data (cfg_data),
    .cfg  (cfg)
  );

  sdh_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_cmd   (in_bus.cmd),
    .in_sector(in_bus.sector),
    .in_byte  (in_bus.byte_in),
    .cfg      (cfg),
    .push     (push)
  );

  sdh_rq u_rq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (out_bus.valid & out_bus.ready),
    .valid(out_bus.valid),
    .head (head),
    .count(rq_count)
  );

  assign out_bus.kind             = head.kind;
  assign out_bus.bus_byte         = head.bus_byte;
  assign out_bus.chip_select      = head.chip_select;
  assign out_bus.status           = head.status;
  assign out_bus.card_kind        = head.card_kind;
  assign out_bus.block_addressing = head.block_addressing;
  assign out_bus.last             = head.last;
endmodule

@@ src/sdh_checker.sv @@
// ----------------------------------------------------------------------------
// sdh_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sdh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic       out_cs,
  input logic [2:0] out_status,
  input logic       out_last
);
  import sdh_pkg::*;

  // A pending beat is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Done releases chip select and ends its input
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_DONE |-> !out_cs && out_last)
    else $error("done beat with chip select or not last");

  // Status only in done beats
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_DONE |-> out_status == ST_OK)
    else $error("status outside done beat");

  // Read data comes with the card selected and a bus byte after it
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_DATA |-> out_cs && !out_last)
    else $error("read data beat malformed");
endmodule

bind sd_card_spi_host_sequencer_top sdh_checker u_sdh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_kind  (out_bus.kind),
  .out_cs    (out_bus.chip_select),
  .out_status(out_bus.status),
  .out_last  (out_bus.last)
);
